// ===== rtl/sbpq_pkg.sv =====
// Package with the types and codes shared by the shared-buffer priority queue.
`timescale 1ns / 1ps

package sbpq_pkg;

    // Request operation codes.
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Number of priority levels and the width of a level index.
    localparam int NUM_QUEUES = 4;
    localparam int QW         = 2;

    // Sequencer states.
    typedef enum logic [0:0] {
        FSM_IDLE = 1'b0,
        FSM_EXEC = 1'b1
    } fsm_state_t;

endpackage

// ===== rtl/shared_buffer_priority_queue.sv =====
// Four strict-priority FIFO queues threaded as linked lists through one packet buffer.
`timescale 1ns / 1ps

// A request is taken in the idle state and its slot is read into registers; the update then runs
// in the EXEC state and the result strobe is registered from it (read, then update).
// A new request is taken only once the update is over; the link memory read must land before the update.
// busy is high for the single update cycle after each accepted request.
// Reset clears the list pointers, counters and queue flags; the slot memories are not
// cleared, as every slot is written before it is read. The receiver cannot stall results.
module shared_buffer_priority_queue #(
    parameter int DEPTH = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        opcode,
    input  logic [1:0]  priority_req,
    input  logic [31:0] arrival_stamp,
    output logic        done,
    output logic [1:0]  status,
    output logic [31:0] out_time,
    output logic [1:0]  out_priority,
    output logic [7:0]  stored_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = (CW > 8) ? CW : 8;
    localparam int DW = 32 + sbpq_pkg::QW;

    // Slot stores: timestamp with priority, and the list links.
    logic [DW-1:0] data_mem [DEPTH];
    logic [AW-1:0] link_mem [DEPTH];

    sbpq_pkg::fsm_state_t state_reg, state_next;

    logic [AW-1:0] head_reg [sbpq_pkg::NUM_QUEUES];
    logic [AW-1:0] head_next [sbpq_pkg::NUM_QUEUES];
    logic [AW-1:0] tail_reg [sbpq_pkg::NUM_QUEUES];
    logic [AW-1:0] tail_next [sbpq_pkg::NUM_QUEUES];
    logic [sbpq_pkg::NUM_QUEUES-1:0] nonempty_reg, nonempty_next;
    logic [AW-1:0] hole_head_reg, hole_head_next;
    logic [AW-1:0] hole_tail_reg, hole_tail_next;
    logic [CW-1:0] hole_count_reg, hole_count_next;
    logic [CW-1:0] fresh_count_reg, fresh_count_next;
    logic [CW-1:0] occ_reg, occ_next;

    // Request captured at acceptance.
    logic                   op_reg;
    logic [sbpq_pkg::QW-1:0] pr_reg;
    logic [31:0]            time_reg;
    logic [sbpq_pkg::QW-1:0] q_reg;
    logic                   none_reg;
    logic [AW-1:0]          slot_reg;

    // Memory read data.
    logic [DW-1:0] data_rd_reg;
    logic [AW-1:0] link_rd_reg;

    // Result registers.
    logic        done_reg, done_next;
    logic [1:0]  status_reg, status_next;
    logic [31:0] out_time_reg, out_time_next;
    logic [1:0]  out_pri_reg, out_pri_next;
    logic [CW-1:0] count_reg;

    logic                    accept;
    logic [sbpq_pkg::QW-1:0] first_q;
    logic                    any_nonempty;
    logic [AW-1:0]           rd_addr;

    logic                    data_we;
    logic [AW-1:0]           data_waddr;
    logic                    link_we;
    logic [AW-1:0]           link_waddr;
    logic [AW-1:0]           link_wdata;
    logic [AW-1:0]           new_slot;
    logic [sbpq_pkg::QW-1:0] idx;
    logic [AW-1:0]           tail_sel;
    logic                    full;
    logic [EW-1:0]           count_ext;

    assign accept = start && (state_reg == sbpq_pkg::FSM_IDLE);

    // The lowest-numbered non-empty queue is served first.
    always_comb
    begin
        first_q = '0;
        for (int i = sbpq_pkg::NUM_QUEUES - 1; i >= 0; i--)
        begin
            if (nonempty_reg[i])
            begin
                first_q = sbpq_pkg::QW'(i);
            end
        end
        any_nonempty = |nonempty_reg;
    end

    // A dequeue reads the served head slot; an enqueue reads the link of the free-list head.
    assign rd_addr = (opcode == sbpq_pkg::OP_DEQUEUE) ? head_reg[first_q] : hole_head_reg;

    // Next state of the sequencer.
    always_comb
    begin
        case (state_reg)
            sbpq_pkg::FSM_IDLE: state_next = start ? sbpq_pkg::FSM_EXEC : sbpq_pkg::FSM_IDLE;
            sbpq_pkg::FSM_EXEC: state_next = sbpq_pkg::FSM_IDLE;
            default:            state_next = sbpq_pkg::FSM_IDLE;
        endcase
    end

    // Handshake outputs of the sequencer.
    always_comb
    begin
        case (state_reg)
            sbpq_pkg::FSM_IDLE: busy = 1'b0;
            sbpq_pkg::FSM_EXEC: busy = 1'b1;
            default:            busy = 1'b1;
        endcase
    end

    // Capture the request and the values it depends on.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= opcode;
            pr_reg   <= priority_req;
            time_reg <= arrival_stamp;
            q_reg    <= first_q;
            none_reg <= !any_nonempty;
            slot_reg <= head_reg[first_q];
        end
    end

    // Update step: list surgery, counters and the result, from the read data.
    assign idx      = (op_reg == sbpq_pkg::OP_DEQUEUE) ? q_reg : pr_reg;
    assign tail_sel = tail_reg[idx];
    assign full     = (occ_reg >= CW'(DEPTH)) ||
                      ((hole_count_reg == '0) && (fresh_count_reg >= CW'(DEPTH)));
    assign new_slot = (hole_count_reg != '0) ? hole_head_reg : fresh_count_reg[AW-1:0];

    always_comb
    begin
        head_next        = head_reg;
        tail_next        = tail_reg;
        nonempty_next    = nonempty_reg;
        hole_head_next   = hole_head_reg;
        hole_tail_next   = hole_tail_reg;
        hole_count_next  = hole_count_reg;
        fresh_count_next = fresh_count_reg;
        occ_next         = occ_reg;
        data_we          = 1'b0;
        data_waddr       = new_slot;
        link_we          = 1'b0;
        link_waddr       = tail_sel;
        link_wdata       = new_slot;
        done_next        = 1'b0;
        status_next      = sbpq_pkg::ST_OK;
        out_time_next    = '0;
        out_pri_next     = '0;

        if (state_reg == sbpq_pkg::FSM_EXEC)
        begin
            done_next = 1'b1;
            if (op_reg == sbpq_pkg::OP_ENQUEUE)
            begin
                if (full)
                begin
                    status_next = sbpq_pkg::ST_FULL;
                end
                else
                begin
                    // Take the oldest freed slot, else the next never-used one.
                    if (hole_count_reg != '0)
                    begin
                        if (hole_count_reg > CW'(1))
                        begin
                            hole_head_next = link_rd_reg;
                        end
                        hole_count_next = hole_count_reg - CW'(1);
                    end
                    else
                    begin
                        fresh_count_next = fresh_count_reg + CW'(1);
                    end
                    data_we = 1'b1;
                    if (!nonempty_reg[pr_reg])
                    begin
                        head_next[pr_reg]     = new_slot;
                        nonempty_next[pr_reg] = 1'b1;
                    end
                    else
                    begin
                        link_we = 1'b1;
                    end
                    tail_next[pr_reg] = new_slot;
                    occ_next          = occ_reg + CW'(1);
                end
            end
            else
            begin
                if (none_reg)
                begin
                    status_next = sbpq_pkg::ST_EMPTY;
                end
                else
                begin
                    // Unlink the head slot and append it to the free list.
                    if (slot_reg == tail_sel)
                    begin
                        nonempty_next[q_reg] = 1'b0;
                    end
                    else
                    begin
                        head_next[q_reg] = link_rd_reg;
                    end
                    link_waddr = hole_tail_reg;
                    link_wdata = slot_reg;
                    if (hole_count_reg == '0)
                    begin
                        hole_head_next = slot_reg;
                    end
                    else
                    begin
                        link_we = 1'b1;
                    end
                    hole_tail_next  = slot_reg;
                    hole_count_next = hole_count_reg + CW'(1);
                    if (occ_reg != '0)
                    begin
                        occ_next = occ_reg - CW'(1);
                    end
                    out_time_next = data_rd_reg[31:0];
                    out_pri_next  = data_rd_reg[DW-1:32];
                end
            end
        end
    end

    // Packet store: written on enqueue, read when a request is taken.
    always_ff @(posedge clk)
    begin
        if (data_we)
        begin
            data_mem[data_waddr] <= {pr_reg, time_reg};
        end
        if (accept)
        begin
            data_rd_reg <= data_mem[rd_addr];
        end
    end

    // Link store: one write in the update cycle, one read when a request is taken.
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (accept)
        begin
            link_rd_reg <= link_mem[rd_addr];
        end
    end

    // Control state and list pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= sbpq_pkg::FSM_IDLE;
            for (int i = 0; i < sbpq_pkg::NUM_QUEUES; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
            nonempty_reg    <= '0;
            hole_head_reg   <= '0;
            hole_tail_reg   <= '0;
            hole_count_reg  <= '0;
            fresh_count_reg <= '0;
            occ_reg         <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            nonempty_reg    <= nonempty_next;
            hole_head_reg   <= hole_head_next;
            hole_tail_reg   <= hole_tail_next;
            hole_count_reg  <= hole_count_next;
            fresh_count_reg <= fresh_count_next;
            occ_reg         <= occ_next;
            done_reg        <= done_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == sbpq_pkg::FSM_EXEC)
        begin
            status_reg   <= status_next;
            out_time_reg <= out_time_next;
            out_pri_reg  <= out_pri_next;
            count_reg    <= occ_next;
        end
    end

    assign count_ext    = EW'(count_reg);
    assign done         = done_reg;
    assign status       = status_reg;
    assign out_time     = out_time_reg;
    assign out_priority = out_pri_reg;
    assign stored_count = count_ext[7:0];

`ifndef NO_ASSERTIONS
    // Every slot handed out is either held in a queue or on the free list.
    a_slot_conservation: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg + hole_count_reg) == fresh_count_reg)
        else $error("slot accounting broken");

    // The buffer never holds more packets than it has slots.
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CW'(DEPTH))
        else $error("occupancy above capacity");

    // A taken request keeps the block busy for the update cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after a request");

    // A result strobe only follows an update cycle.
    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == sbpq_pkg::FSM_EXEC))
        else $error("result without an update cycle");

    // An empty report means no queue held a packet.
    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == sbpq_pkg::ST_EMPTY)) |-> (occ_reg == '0))
        else $error("empty reported with packets held");
`endif

endmodule
